[rtl/svd_pkg.sv]
// Shared types and constants for the stereo vibrato delay core.
// Used by svd_ctrl, svd_lane and stereo_vibrato_delay_core; no dependencies.
package svd_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int RATE_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_EFFECT_ENABLE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RATE_DIVIDER  = 1'd1;

  // Per-frame control that the sequencer hands to each channel lane.
  typedef struct packed {
    logic take;     // a frame transfer happens this cycle
    logic write;    // store the sample into the delay line
    logic bypass;   // pass the sample through unchanged
    logic forward;  // read address equals the write address of this frame
    logic stored;   // read address has been written since reset
  } lane_ctl_t;

endpackage

[rtl/svd_ctrl.sv]
// Modulation sequencer: rate counter, sine phase, offset ROM and delay line pointer.
// Produces the write and read addresses shared by both channel lanes.
// Depends on svd_pkg.
module svd_ctrl #(
  parameter int DELAY_DEPTH  = 154,
  parameter int SINE_ENTRIES = 256,
  parameter int PTR_W        = $clog2(DELAY_DEPTH),
  parameter int PH_W         = $clog2(SINE_ENTRIES)
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        accept,
  input  logic                        effect_enable,
  input  logic [svd_pkg::RATE_W-1:0]  rate_divider,
  output logic [PTR_W-1:0]            wr_addr,
  output logic [PTR_W-1:0]            rd_addr,
  output svd_pkg::lane_ctl_t          ctl
);

  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] N_ENT   = 64'(SINE_ENTRIES);
  localparam logic [63:0] N_DEP   = 64'(DELAY_DEPTH);

  logic [PTR_W-1:0] offset_rom [SINE_ENTRIES];

  // Offset table, built at elaboration from a fixed-point Taylor series of the sine.
  for (genvar p = 0; p < SINE_ENTRIES; p++) begin : g_rom
    localparam logic [63:0] A0  = 64'(2 * p);
    localparam bit          NEG = (A0 >= N_ENT);
    localparam logic [63:0] A1  = NEG ? (A0 - N_ENT) : A0;
    localparam logic [63:0] A   = (2 * A1 > N_ENT) ? (N_ENT - A1) : A1;
    localparam logic [63:0] X   = (PI_Q30 * A) / N_ENT;
    localparam logic [63:0] X2  = (X * X) >> 30;
    localparam logic [63:0] T1  = ((X  * X2) >> 30) / 64'd6;
    localparam logic [63:0] T2  = ((T1 * X2) >> 30) / 64'd20;
    localparam logic [63:0] T3  = ((T2 * X2) >> 30) / 64'd42;
    localparam logic [63:0] T4  = ((T3 * X2) >> 30) / 64'd72;
    localparam logic [63:0] T5  = ((T4 * X2) >> 30) / 64'd110;
    localparam logic [63:0] T6  = ((T5 * X2) >> 30) / 64'd156;
    localparam logic [63:0] T7  = ((T6 * X2) >> 30) / 64'd210;
    localparam logic [63:0] T8  = ((T7 * X2) >> 30) / 64'd272;
    localparam logic [63:0] SUM = X - T1 + T2 - T3 + T4 - T5 + T6 - T7 + T8;
    localparam logic [63:0] SER = (SUM > Q30_ONE) ? Q30_ONE : SUM;
    localparam logic [63:0] S   = (A == 64'd0)         ? 64'd0 :
                                  (2 * A == N_ENT)     ? Q30_ONE :
                                  (6 * A == N_ENT)     ? (Q30_ONE / 2) : SER;
    localparam logic [63:0] V   = NEG ? (Q30_ONE - S) : (Q30_ONE + S);
    localparam logic [63:0] OFF = ((V * N_DEP) >> 31) % N_DEP;
    assign offset_rom[p] = OFF[PTR_W-1:0];
  end

  logic [svd_pkg::RATE_W-1:0] rate_count, rate_count_next;
  logic [PH_W-1:0]            phase, phase_next;
  logic [PTR_W-1:0]           wr_ptr, wr_ptr_next;
  logic                       full, full_next;
  logic                       step;
  logic                       wrap;
  logic [PTR_W-1:0]           offset;
  logic [PTR_W:0]             rd_sum;
  logic                       advance;

  assign advance = accept && effect_enable;
  assign step    = (rate_count >= rate_divider);
  assign wrap    = (wr_ptr == PTR_W'(DELAY_DEPTH - 1));

  always_comb begin
    rate_count_next = step ? '0 : rate_count + 1'b1;
    if (step) begin
      phase_next = (phase == PH_W'(SINE_ENTRIES - 1)) ? '0 : phase + 1'b1;
    end else begin
      phase_next = phase;
    end
    wr_ptr_next = wrap ? '0 : wr_ptr + 1'b1;
    full_next   = full || wrap;
  end

  // The phase is stepped before the lookup, so the offset uses the new phase.
  assign offset  = offset_rom[phase_next];
  assign rd_sum  = {1'b0, wr_ptr_next} + {1'b0, offset};
  assign wr_addr = wr_ptr;

  always_comb begin
    if (rd_sum >= (PTR_W + 1)'(DELAY_DEPTH)) begin
      rd_addr = PTR_W'(rd_sum - (PTR_W + 1)'(DELAY_DEPTH));
    end else begin
      rd_addr = rd_sum[PTR_W-1:0];
    end
  end

  // Writes sweep the line in order from entry zero, so an entry is written
  // once the line has wrapped or the entry lies at or below the write pointer.
  always_comb begin
    ctl.take    = accept;
    ctl.write   = advance;
    ctl.bypass  = !effect_enable;
    ctl.forward = (rd_addr == wr_ptr);
    ctl.stored  = full || (rd_addr <= wr_ptr);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_count <= '0;
      phase      <= '0;
      wr_ptr     <= '0;
      full       <= 1'b0;
    end else if (advance) begin
      rate_count <= rate_count_next;
      phase      <= phase_next;
      wr_ptr     <= wr_ptr_next;
      full       <= full_next;
    end
  end

endmodule

[rtl/svd_lane.sv]
// One channel lane: circular delay line memory with registered read and
// same-address forwarding. Depends on svd_pkg.
module svd_lane #(
  parameter int DELAY_DEPTH = 154,
  parameter int PTR_W       = $clog2(DELAY_DEPTH)
) (
  input  logic                                clk,
  input  svd_pkg::lane_ctl_t                  ctl,
  input  logic [PTR_W-1:0]                    wr_addr,
  input  logic [PTR_W-1:0]                    rd_addr,
  input  logic signed [svd_pkg::SAMPLE_W-1:0] din,
  output logic signed [svd_pkg::SAMPLE_W-1:0] dout
);

  logic [svd_pkg::SAMPLE_W-1:0] mem [DELAY_DEPTH];
  logic [svd_pkg::SAMPLE_W-1:0] rd_data;
  logic [svd_pkg::SAMPLE_W-1:0] din_q;
  logic                         pass_q;
  logic                         stored_q;

  always_ff @(posedge clk) begin
    if (ctl.write) begin
      mem[wr_addr] <= din;
    end
    if (ctl.take) begin
      rd_data <= mem[rd_addr];
    end
  end

  // A read of the entry written by the same frame takes the incoming sample.
  always_ff @(posedge clk) begin
    if (ctl.take) begin
      din_q    <= din;
      pass_q   <= ctl.bypass || ctl.forward;
      stored_q <= ctl.stored;
    end
  end

  always_comb begin
    if (pass_q) begin
      dout = din_q;
    end else if (stored_q) begin
      dout = rd_data;
    end else begin
      dout = '0;
    end
  end

endmodule

[rtl/stereo_vibrato_delay_core.sv]
// Stereo vibrato delay core: two delay line lanes behind one modulation sequencer.
// The memory read register loads at the input transfer, the output register when the read
// stage advances into a free output. Throughput: one frame per cycle while the output is not
// stalled, set by the one write and one registered read per cycle of each lane's delay memory.
// Reset: synchronous; no clearing pass is needed, entries not yet written read as zero.
// Depends on svd_pkg, svd_ctrl, svd_lane.
module stereo_vibrato_delay_core #(
  parameter int DELAY_DEPTH  = 154,
  parameter int SINE_ENTRIES = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [svd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [svd_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [svd_pkg::SAMPLE_W-1:0]  left_in,
  input  logic signed [svd_pkg::SAMPLE_W-1:0]  right_in,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [svd_pkg::SAMPLE_W-1:0]  left_out,
  output logic signed [svd_pkg::SAMPLE_W-1:0]  right_out
);

  localparam int PTR_W = $clog2(DELAY_DEPTH);
  localparam int PH_W  = $clog2(SINE_ENTRIES);

  logic                             effect_enable;
  logic [svd_pkg::RATE_W-1:0]       rate_divider;
  logic                             accept;
  logic                             advance;
  logic                             s1_valid;
  logic [PTR_W-1:0]                 wr_addr;
  logic [PTR_W-1:0]                 rd_addr;
  svd_pkg::lane_ctl_t               ctl;
  logic signed [svd_pkg::SAMPLE_W-1:0] left_lane;
  logic signed [svd_pkg::SAMPLE_W-1:0] right_lane;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_enable <= 1'b0;
      rate_divider  <= svd_pkg::RATE_W'(42);
    end else if (cfg_write) begin
      case (cfg_index)
        svd_pkg::REG_EFFECT_ENABLE: effect_enable <= cfg_data[0];
        svd_pkg::REG_RATE_DIVIDER:  rate_divider  <= cfg_data[svd_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // The read stage moves on whenever the output register is empty or being taken,
  // so a new frame transfer can happen while a result still waits at the output.
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;
  assign accept   = in_valid && in_ready;

  svd_ctrl #(
    .DELAY_DEPTH  (DELAY_DEPTH),
    .SINE_ENTRIES (SINE_ENTRIES),
    .PTR_W        (PTR_W),
    .PH_W         (PH_W)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .effect_enable (effect_enable),
    .rate_divider  (rate_divider),
    .wr_addr       (wr_addr),
    .rd_addr       (rd_addr),
    .ctl           (ctl)
  );

  svd_lane #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .PTR_W       (PTR_W)
  ) u_lane_left (
    .clk     (clk),
    .ctl     (ctl),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .din     (left_in),
    .dout    (left_lane)
  );

  svd_lane #(
    .DELAY_DEPTH (DELAY_DEPTH),
    .PTR_W       (PTR_W)
  ) u_lane_right (
    .clk     (clk),
    .ctl     (ctl),
    .wr_addr (wr_addr),
    .rd_addr (rd_addr),
    .din     (right_in),
    .dout    (right_lane)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Merge the two lanes into one output frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      left_out  <= left_lane;
      right_out <= right_lane;
    end
  end

endmodule

[tb/svd_frame_checker.sv]
`timescale 1ns / 1ps
// Frame checker for stereo_vibrato_delay_core: watches the register port and both channels,
// predicts each output frame and compares it. Depends on svd_pkg.
module svd_frame_checker #(
  parameter int DELAY_DEPTH  = 154,
  parameter int SINE_ENTRIES = 256
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [svd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [svd_pkg::CFG_W-1:0]            cfg_data,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic signed [svd_pkg::SAMPLE_W-1:0]  left_in,
  input  logic signed [svd_pkg::SAMPLE_W-1:0]  right_in,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [svd_pkg::SAMPLE_W-1:0]  left_out,
  input  logic signed [svd_pkg::SAMPLE_W-1:0]  right_out,
  output int                                   mismatches,
  output int                                   pending,
  output int                                   checked
);

  localparam longint unsigned Q30    = 64'd1073741824;
  localparam longint unsigned PI_Q30 = 64'd3373259426;

  typedef struct packed {
    logic [svd_pkg::SAMPLE_W-1:0] left;
    logic [svd_pkg::SAMPLE_W-1:0] right;
  } frame_t;

  int                           tap_offset [SINE_ENTRIES];
  logic [svd_pkg::SAMPLE_W-1:0] left_line  [DELAY_DEPTH];
  logic [svd_pkg::SAMPLE_W-1:0] right_line [DELAY_DEPTH];
  int                           wr_left, wr_right, phase, rate_cnt;
  logic                         fx_on;
  logic [svd_pkg::RATE_W-1:0]   divider;
  frame_t                       due_frames [$];

  // Sine of pi*num/den in unsigned Q30, first quadrant only, truncating Taylor series.
  function automatic longint unsigned sine_q30(longint unsigned num, longint unsigned den);
    longint unsigned x, x2, term, acc, k;
    if (num == 0) return 0;
    if (2 * num == den) return Q30;
    if (6 * num == den) return Q30 / 2;
    x = PI_Q30 * num / den;
    x2 = (x * x) >> 30;
    term = x;
    acc = x;
    for (k = 1; k <= 8; k++) begin
      term = ((term * x2) >> 30) / ((2 * k) * (2 * k + 1));
      if (k[0]) acc -= term;
      else acc += term;
    end
    if (acc > Q30) acc = Q30;
    return acc;
  endfunction

  initial begin : build_taps
    longint unsigned a, s, v;
    bit neg;
    for (int p = 0; p < SINE_ENTRIES; p++) begin
      a = 2 * p;
      neg = 0;
      if (a >= SINE_ENTRIES) begin
        neg = 1;
        a -= SINE_ENTRIES;
      end
      if (2 * a > SINE_ENTRIES) a = SINE_ENTRIES - a;
      s = sine_q30(a, SINE_ENTRIES);
      v = neg ? (Q30 - s) : (Q30 + s);
      tap_offset[p] = int'(((v * DELAY_DEPTH) >> 31) % DELAY_DEPTH);
    end
  end

  task automatic clear_state();
    foreach (left_line[i]) left_line[i] = '0;
    foreach (right_line[i]) right_line[i] = '0;
    wr_left = 0;
    wr_right = 0;
    phase = 0;
    rate_cnt = 0;
    fx_on = 1'b0;
    divider = 16'd42;
    due_frames.delete();
  endtask

  // One stereo frame through the vibrato; in bypass nothing moves.
  task automatic run_vibrato(input logic [svd_pkg::SAMPLE_W-1:0] l,
                             input logic [svd_pkg::SAMPLE_W-1:0] r,
                             output frame_t res);
    int off;
    if (!fx_on) begin
      res = '{left: l, right: r};
      return;
    end
    if (rate_cnt >= int'(divider)) begin
      rate_cnt = 0;
      phase = (phase + 1) % SINE_ENTRIES;
    end else begin
      rate_cnt++;
    end
    off = tap_offset[phase];
    left_line[wr_left] = l;
    wr_left = (wr_left + 1) % DELAY_DEPTH;
    res.left = left_line[(wr_left + off) % DELAY_DEPTH];
    right_line[wr_right] = r;
    wr_right = (wr_right + 1) % DELAY_DEPTH;
    res.right = right_line[(wr_right + off) % DELAY_DEPTH];
  endtask

  task automatic report_field(string name, logic [svd_pkg::SAMPLE_W-1:0] want,
                              logic [svd_pkg::SAMPLE_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("%t: frame %0d %s mismatch: expected %h, got %h", $time, checked, name, want,
               got);
  endtask

  always @(posedge clk) begin
    frame_t due, res;
    if (rst) begin
      clear_state();
      mismatches = 0;
      checked = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          svd_pkg::REG_EFFECT_ENABLE: fx_on = cfg_data[0];
          svd_pkg::REG_RATE_DIVIDER:  divider = cfg_data[svd_pkg::RATE_W-1:0];
          default: ;
        endcase
      end
      // Outputs are compared before this edge's input is predicted, so an early
      // output can never match a frame that was only just taken.
      if (out_valid && out_ready) begin
        if (due_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t: output L=%h R=%h with no frame outstanding", $time, left_out,
                     right_out);
        end else begin
          due = due_frames.pop_front();
          if (left_out !== due.left) report_field("left", due.left, left_out);
          if (right_out !== due.right) report_field("right", due.right, right_out);
        end
        checked++;
      end
      if (in_valid && in_ready) begin
        run_vibrato(left_in, right_in, res);
        due_frames.push_back(res);
      end
    end
    pending = due_frames.size();
  end

endmodule

[tb/tb_stereo_vibrato_delay_core.sv]
`timescale 1ns / 1ps
// Top testbench for stereo_vibrato_delay_core: drives frames, register writes and output
// stalls, and gives the verdict. Depends on svd_pkg and svd_frame_checker.
module tb_stereo_vibrato_delay_core;

  localparam int DELAY_DEPTH  = 154;
  localparam int SINE_ENTRIES = 256;

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                cfg_write;
  logic [svd_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [svd_pkg::CFG_W-1:0]           cfg_data;
  logic                                in_valid;
  logic                                in_ready;
  logic signed [svd_pkg::SAMPLE_W-1:0] left_in;
  logic signed [svd_pkg::SAMPLE_W-1:0] right_in;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [svd_pkg::SAMPLE_W-1:0] left_out;
  logic signed [svd_pkg::SAMPLE_W-1:0] right_out;

  int mismatches, pending, checked;
  int settings_used;
  bit stalls_on;
  int stall_left = 0;

  always #5 clk = ~clk;

  stereo_vibrato_delay_core #(
    .DELAY_DEPTH(DELAY_DEPTH),
    .SINE_ENTRIES(SINE_ENTRIES)
  ) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .left_in(left_in), .right_in(right_in),
    .out_valid(out_valid), .out_ready(out_ready), .left_out(left_out), .right_out(right_out)
  );

  svd_frame_checker #(
    .DELAY_DEPTH(DELAY_DEPTH),
    .SINE_ENTRIES(SINE_ENTRIES)
  ) checker_i (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .left_in(left_in), .right_in(right_in),
    .out_valid(out_valid), .out_ready(out_ready), .left_out(left_out), .right_out(right_out),
    .mismatches(mismatches), .pending(pending), .checked(checked)
  );

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return 0;
    if (pick < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [svd_pkg::SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return 24'h7FFFFF;
      1: return 24'h800000;
      2: return svd_pkg::SAMPLE_W'($signed($urandom_range(0, 31)) - 16);
      default: return svd_pkg::SAMPLE_W'($urandom);
    endcase
  endfunction

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (stalls_on && gap_length() > 0) begin
      stall_left = gap_length();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_frame(input logic [svd_pkg::SAMPLE_W-1:0] l,
                            input logic [svd_pkg::SAMPLE_W-1:0] r);
    in_valid <= 1'b1;
    left_in <= l;
    right_in <= r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Holds the sender until every outstanding frame has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [svd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [svd_pkg::CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
    @(negedge clk);
  endtask

  // The upper bits of the enable write are junk that the block must ignore.
  task automatic configure(input bit enable, input logic [svd_pkg::RATE_W-1:0] divider);
    drain();
    write_reg(svd_pkg::REG_EFFECT_ENABLE, {15'($urandom), enable});
    write_reg(svd_pkg::REG_RATE_DIVIDER, divider);
    settings_used++;
  endtask

  task automatic run_random(input int frames, input bit gaps, input bit stalls);
    int g;
    stalls_on = stalls;
    for (int i = 0; i < frames; i++) begin
      send_frame(random_sample(), random_sample());
      if (gaps) begin
        g = gap_length();
        if (g > 0) idle_sender(g);
        if ($urandom_range(0, 149) == 0) drain();
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    left_in = '0;
    right_in = '0;
    stalls_on = 1'b0;
    settings_used = 1;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset configuration is bypass: extremes must come straight through.
    send_frame(24'h800000, 24'h7FFFFF);
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h000000, 24'hFFFFFF);
    send_frame(24'h555555, 24'hAAAAAA);

    // Fastest modulation: the phase steps on every frame.
    configure(1'b1, 16'd0);
    send_frame(24'h7FFFFF, 24'h800000);
    send_frame(24'h800000, 24'h7FFFFF);
    send_frame(24'hFFFFFF, 24'h000001);
    send_frame(24'hAAAAAA, 24'h555555);

    // Slowest divider lets the rate counter climb; lowering the divider below the
    // count must step the phase on the very next frame.
    configure(1'b1, 16'hFFFF);
    repeat (6) send_frame(random_sample(), random_sample());
    drain();
    write_reg(svd_pkg::REG_RATE_DIVIDER, 16'd3);
    repeat (2) send_frame(random_sample(), random_sample());

    // Bypass in the middle of a run must leave the delay lines and phase untouched.
    drain();
    write_reg(svd_pkg::REG_EFFECT_ENABLE, 16'hFFFE);
    repeat (3) send_frame(random_sample(), random_sample());
    drain();
    write_reg(svd_pkg::REG_EFFECT_ENABLE, 16'h0001);
    repeat (3) send_frame(random_sample(), random_sample());

    configure(1'b1, 16'd0);
    run_random(300, 1'b1, 1'b1);
    configure(1'b1, svd_pkg::RATE_W'($urandom_range(0, 3)));
    run_random(100, 1'b0, 1'b0);
    configure(1'b0, 16'hFFFF);
    run_random(60, 1'b1, 1'b1);
    configure(1'b1, 16'hFFFF);
    run_random(80, 1'b1, 1'b1);
    configure(1'b1, svd_pkg::RATE_W'($urandom_range(1, 20)));
    run_random(130, 1'b1, 1'b1);
    configure(1'b1, 16'd42);
    run_random(80, 1'b1, 1'b1);

    drain();
    repeat (10) @(negedge clk);
    $display("Checked %0d stereo frames under %0d register settings,", checked, settings_used);
    $display("covering bypass, full sine sweeps and rate dividers from 0 to 65535.");
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
